@@ rtl/chunked_bump_allocator_unit_defines.svh @@
// Assertion macros for the allocator RTL.
`ifndef CHUNKED_BUMP_ALLOCATOR_UNIT_DEFINES_SVH
`define CHUNKED_BUMP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cba_pkg.sv @@
package cba_pkg;

  // Fixed widths of the transaction fields.
  localparam int CMD_W       = 1;
  localparam int BYTES_W     = 14;
  localparam int ALIGN_W     = 13;
  localparam int CHUNK_SEL_W = 3;
  localparam int STATUS_W    = 2;
  localparam int OFFSET_W    = 13;

  // Rounded size in granules never exceeds the raw byte count.
  localparam int Q_W = BYTES_W;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_ALIGN  = 2'd1,
    STAT_SIZE   = 2'd2,
    STAT_NOFIT  = 2'd3
  } cba_status_t;

  // Broadcast to every cell during the commit cycle.
  typedef struct packed {
    logic                   alloc_go;
    logic                   free_go;
    logic [Q_W-1:0]         q;
    logic [CHUNK_SEL_W-1:0] chunk;
  } cba_ctl_t;

endpackage

@@ rtl/cba_cell.sv @@
module cba_cell #(
  parameter int IDX     = 0,
  parameter int IDX_W   = 3,
  parameter int G_W     = 10,
  parameter int CAP_G   = 512,
  parameter int SAT_G   = 512,
  parameter bit HAS_REM = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cba_pkg::cba_ctl_t ctl_i,
  input  logic              taken_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [G_W-1:0]    fg_i,
  output logic              taken_o,
  output logic [IDX_W-1:0]  idx_o,
  output logic [G_W-1:0]    fg_o
);
  import cba_pkg::*;

  localparam int S_W   = ((G_W > Q_W) ? G_W : Q_W) + 1;
  localparam bit REACH = (IDX < (1 << CHUNK_SEL_W));

  // Fill and freed counts, both in granules.
  logic [G_W-1:0] fill_r, fill_nxt;
  logic [G_W-1:0] freed_r, freed_nxt;
  logic [S_W-1:0] alloc_sum;
  logic [S_W-1:0] free_sum;
  logic [G_W-1:0] freed_sat;
  logic           fit;
  logic           win;
  logic           hit;

  always_comb begin
    alloc_sum = S_W'(fill_r) + S_W'(ctl_i.q);
    // A chunk filled exactly to the end never takes even a zero-size request.
    fit = (alloc_sum <= S_W'(CAP_G)) && (HAS_REM || (fill_r != G_W'(CAP_G)));
    win = ctl_i.alloc_go && fit && !taken_i;
    hit = ctl_i.free_go && REACH && (ctl_i.chunk == CHUNK_SEL_W'(IDX));

    // Past the granule capacity the freed count pins at the saturation mark.
    free_sum  = S_W'(freed_r) + S_W'(ctl_i.q);
    freed_sat = (free_sum > S_W'(CAP_G)) ? G_W'(SAT_G) : free_sum[G_W-1:0];

    fill_nxt  = fill_r;
    freed_nxt = freed_r;
    if (win) begin
      fill_nxt = alloc_sum[G_W-1:0];
    end
    if (hit) begin
      if (freed_sat == fill_r) begin
        fill_nxt  = '0;
        freed_nxt = '0;
      end else begin
        freed_nxt = freed_sat;
      end
    end
  end

  always_comb begin
    taken_o = taken_i || win;
    idx_o   = win ? IDX_W'(IDX) : idx_i;
    fg_o    = win ? fill_r : fg_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      freed_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      freed_r <= freed_nxt;
    end
  end

endmodule

@@ rtl/chunked_bump_allocator_unit.sv @@
// Chunked bump allocator: NUM_CHUNKS arenas of CHUNK_BYTES bytes each.
// Input channel (in_valid/in_stall): cmd 0 allocates byte_count bytes with
// the given alignment, cmd 1 frees byte_count bytes back to free_chunk.
// Sizes round up to GRANULE. Each transaction yields exactly one result on
// the output channel (out_valid/out_stall): status, chunk_index and offset.
// Allocation takes the lowest-numbered chunk whose tail fits; errors leave
// all state unchanged and report chunk 0, offset 0.
// The request is rounded and registered at acceptance, then the commit cycle
// runs the fit check through the chain of chunk cells, where each cell claims
// the request or hands it to its neighbor, and loads the result register that
// drives out_valid. No new transaction is taken before the last one commits.
// in_stall is high during the commit cycle, and stays high while a finished
// result waits in the output register and the next one is ready to commit.
// A stalled result holds its value on the output ports.
// Synchronous reset (rst_n low) empties all chunks and drops any pending
// result; the block takes transactions as soon as reset is released.
`include "chunked_bump_allocator_unit_defines.svh"

module chunked_bump_allocator_unit #(
  parameter int CHUNK_BYTES = 8192,
  parameter int NUM_CHUNKS  = 8,
  parameter int GRANULE     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cba_pkg::CMD_W-1:0]         in_cmd,
  input  logic [cba_pkg::BYTES_W-1:0]       in_byte_count,
  input  logic [cba_pkg::ALIGN_W-1:0]       in_alignment,
  input  logic [cba_pkg::CHUNK_SEL_W-1:0]   in_free_chunk,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cba_pkg::STATUS_W-1:0]      out_status,
  output logic [cba_pkg::CHUNK_SEL_W-1:0]   out_chunk_index,
  output logic [cba_pkg::OFFSET_W-1:0]      out_offset
);
  import cba_pkg::*;

  // Granule bookkeeping, worked out at elaboration.
  localparam int CAP_G   = CHUNK_BYTES / GRANULE;
  localparam bit HAS_REM = (CHUNK_BYTES % GRANULE) != 0;
  localparam int SAT_G   = HAS_REM ? CAP_G + 1 : CAP_G;
  localparam int G_W     = $clog2(SAT_G + 1);
  localparam int IDX_W   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CQ_W    = (G_W > Q_W) ? G_W : Q_W;

  // Rounding divide: exact reciprocal multiply, or a shift for powers of two.
  localparam bit G_POW2  = (GRANULE & (GRANULE - 1)) == 0;
  localparam int LOG_G   = $clog2(GRANULE);
  localparam int X_W     = BYTES_W + 1;
  localparam int SH      = X_W + LOG_G;
  localparam int M_W     = X_W + 2;
  localparam int RECIP   = ((1 << SH) + GRANULE - 1) / GRANULE;
  localparam int PROD_W  = X_W + M_W;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } cba_state_t;

  cba_state_t               state_r, state_nxt;
  logic [CMD_W-1:0]         cmd_r;
  logic [Q_W-1:0]           q_r;
  logic                     align_bad_r;
  logic [CHUNK_SEL_W-1:0]   chunk_r;
  logic                     out_valid_r, out_valid_nxt;
  cba_status_t              out_status_r;
  logic [CHUNK_SEL_W-1:0]   out_chunk_r;
  logic [G_W-1:0]           out_fg_r;

  logic [X_W-1:0]           bytes_up;
  logic [PROD_W-1:0]        prod;
  logic [Q_W-1:0]           q_calc;
  logic                     in_take;
  logic                     commit;
  logic                     size_bad;
  cba_ctl_t                 ctl;

  logic                     link_taken [NUM_CHUNKS+1];
  logic [IDX_W-1:0]         link_idx   [NUM_CHUNKS+1];
  logic [G_W-1:0]           link_fg    [NUM_CHUNKS+1];

  assign bytes_up = X_W'(in_byte_count) + X_W'(GRANULE - 1);
  assign prod     = PROD_W'(bytes_up) * PROD_W'(RECIP);
  assign q_calc   = G_POW2 ? Q_W'(bytes_up >> LOG_G) : Q_W'(prod >> SH);

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign commit   = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);
  assign size_bad = (CQ_W'(q_r) > CQ_W'(CAP_G));

  always_comb begin
    ctl.alloc_go = commit && (cmd_r == CMD_ALLOC) && !align_bad_r && !size_bad;
    ctl.free_go  = commit && (cmd_r == CMD_FREE);
    ctl.q        = q_r;
    ctl.chunk    = chunk_r;
  end

  // Head of the chain: nothing claimed yet.
  assign link_taken[0] = 1'b0;
  assign link_idx[0]   = '0;
  assign link_fg[0]    = '0;

  for (genvar i = 0; i < NUM_CHUNKS; i++) begin : g_cell
    cba_cell #(
      .IDX     (i),
      .IDX_W   (IDX_W),
      .G_W     (G_W),
      .CAP_G   (CAP_G),
      .SAT_G   (SAT_G),
      .HAS_REM (HAS_REM)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .taken_i (link_taken[i]),
      .idx_i   (link_idx[i]),
      .fg_i    (link_fg[i]),
      .taken_o (link_taken[i+1]),
      .idx_o   (link_idx[i+1]),
      .fg_o    (link_fg[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request registers, loaded at acceptance.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r       <= in_cmd;
      q_r         <= q_calc;
      align_bad_r <= (in_alignment > ALIGN_W'(GRANULE));
      chunk_r     <= in_free_chunk;
    end
  end

  // Result register, loaded in the commit cycle.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= STAT_OK;
      out_chunk_r  <= '0;
      out_fg_r     <= '0;
      if (cmd_r == CMD_FREE) begin
        out_chunk_r <= chunk_r;
      end else if (align_bad_r) begin
        out_status_r <= STAT_ALIGN;
      end else if (size_bad) begin
        out_status_r <= STAT_SIZE;
      end else if (link_taken[NUM_CHUNKS]) begin
        out_chunk_r <= CHUNK_SEL_W'(link_idx[NUM_CHUNKS]);
        out_fg_r    <= link_fg[NUM_CHUNKS];
      end else begin
        out_status_r <= STAT_NOFIT;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chunk_index = out_chunk_r;
  assign out_offset      = OFFSET_W'(out_fg_r * GRANULE);

  `CBA_ASSERT_NEXT(a_take_to_commit, in_take, state_r == S_COMMIT, "accept did not start commit")
  `CBA_ASSERT_NEXT(a_align_status, commit && (cmd_r == CMD_ALLOC) && align_bad_r, out_valid && (out_status == STAT_ALIGN) && (out_offset == '0), "bad alignment not flagged")
  `CBA_ASSERT_NEXT(a_free_result, commit && (cmd_r == CMD_FREE), out_valid && (out_status == STAT_OK) && (out_offset == '0), "free result malformed")
  `CBA_ASSERT_NOW(a_commit_blocks_input, state_r == S_COMMIT, in_stall, "input open during commit")

endmodule

@@ tb/sv/alloc_checker.sv @@
`timescale 1ns / 1ps

module alloc_checker #(
  parameter int CHUNK_BYTES = 8192,
  parameter int NUM_CHUNKS  = 8,
  parameter int GRANULE     = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [cba_pkg::CMD_W-1:0]       in_cmd,
  input  logic [cba_pkg::BYTES_W-1:0]     in_byte_count,
  input  logic [cba_pkg::ALIGN_W-1:0]     in_alignment,
  input  logic [cba_pkg::CHUNK_SEL_W-1:0] in_free_chunk,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cba_pkg::STATUS_W-1:0]    out_status,
  input  logic [cba_pkg::CHUNK_SEL_W-1:0] out_chunk_index,
  input  logic [cba_pkg::OFFSET_W-1:0]    out_offset,
  output int                              fail_count,
  output int                              pending_count
);

  import cba_pkg::*;

  typedef struct packed {
    cba_status_t            status;
    logic [CHUNK_SEL_W-1:0] chunk;
    logic [OFFSET_W-1:0]    offset;
  } alloc_result_t;

  logic [BYTES_W-1:0] fill_level_q [NUM_CHUNKS];
  logic [BYTES_W-1:0] freed_q [NUM_CHUNKS];
  alloc_result_t      awaited_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Applies one transaction to the shadow arenas and returns the grant it earns.
  function automatic alloc_result_t serve_request(logic [CMD_W-1:0] cmd,
                                                  logic [BYTES_W-1:0] bytes,
                                                  logic [ALIGN_W-1:0] align,
                                                  logic [CHUNK_SEL_W-1:0] chunk);
    int            rounded;
    int            fr;
    logic          placed;
    alloc_result_t r;
    rounded  = ((int'(bytes) + GRANULE - 1) / GRANULE) * GRANULE;
    r.status = STAT_OK;
    r.chunk  = '0;
    r.offset = '0;
    placed   = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (int'(align) > GRANULE) begin
        r.status = STAT_ALIGN;
      end else if (rounded > CHUNK_BYTES) begin
        r.status = STAT_SIZE;
      end else begin
        r.status = STAT_NOFIT;
        // first fit; a full chunk never fits, even for zero bytes
        for (int i = 0; i < NUM_CHUNKS; i++) begin
          if (!placed && int'(fill_level_q[i]) < CHUNK_BYTES &&
              CHUNK_BYTES - int'(fill_level_q[i]) >= rounded) begin
            r.status        = STAT_OK;
            r.chunk         = CHUNK_SEL_W'(i);
            r.offset        = OFFSET_W'(fill_level_q[i]);
            fill_level_q[i] = BYTES_W'(int'(fill_level_q[i]) + rounded);
            placed          = 1'b1;
          end
        end
      end
    end else begin
      r.chunk = chunk;
      if (int'(chunk) < NUM_CHUNKS) begin
        fr = int'(freed_q[chunk]) + rounded;
        if (fr > CHUNK_BYTES) begin
          fr = CHUNK_BYTES;
        end
        if (fr == int'(fill_level_q[chunk])) begin
          fill_level_q[chunk] = '0;
          fr = 0;
        end
        freed_q[chunk] = BYTES_W'(fr);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        fill_level_q[i] = '0;
        freed_q[i]      = '0;
      end
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d chunk=%0d offset=%0d",
                   $time, out_status, out_chunk_index, out_offset);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_chunk_index !== want.chunk ||
              out_offset !== want.offset) begin
            $display("%0t: mismatch: expected status=%0d chunk=%0d offset=%0d, got status=%0d chunk=%0d offset=%0d",
                     $time, want.status, want.chunk, want.offset,
                     out_status, out_chunk_index, out_offset);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.insert(awaited_results.size(),
                               serve_request(in_cmd, in_byte_count, in_alignment,
                                             in_free_chunk));
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  import cba_pkg::*;

  localparam int CHUNK_BYTES  = 8192;
  localparam int NUM_CHUNKS   = 8;
  localparam int GRANULE      = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [CHUNK_SEL_W-1:0] chunk;
    logic [BYTES_W-1:0]     bytes;
  } live_block_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [BYTES_W-1:0] bytes;
  } issued_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_cmd;
  logic [BYTES_W-1:0]     in_byte_count;
  logic [ALIGN_W-1:0]     in_alignment;
  logic [CHUNK_SEL_W-1:0] in_free_chunk;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_W-1:0]    out_status;
  logic [CHUNK_SEL_W-1:0] out_chunk_index;
  logic [OFFSET_W-1:0]    out_offset;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int sent_count = 0;
  int granted_count = 0;
  int refused_count = 0;
  int released_count = 0;

  live_block_t live_blocks [$];
  issued_t     issued_q [$];

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_run_left = 0;

  chunked_bump_allocator_unit #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .NUM_CHUNKS  (NUM_CHUNKS),
    .GRANULE     (GRANULE)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_byte_count   (in_byte_count),
    .in_alignment    (in_alignment),
    .in_free_chunk   (in_free_chunk),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_chunk_index (out_chunk_index),
    .out_offset      (out_offset)
  );

  alloc_checker #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .NUM_CHUNKS  (NUM_CHUNKS),
    .GRANULE     (GRANULE)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_byte_count   (in_byte_count),
    .in_alignment    (in_alignment),
    .in_free_chunk   (in_free_chunk),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_chunk_index (out_chunk_index),
    .out_offset      (out_offset),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stalls in runs of differing density.
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    if (rx_run_left == 0) begin
      rx_mode     <= rx_mode_t'($urandom_range(0, 3));
      rx_run_left <= $urandom_range(16, 160);
    end else begin
      rx_run_left <= rx_run_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ~out_stall;
    endcase
  end

  // Track granted blocks so that later frees can hand them back.
  always @(posedge clk) begin
    issued_t     req;
    live_block_t lb;
    if (rst_n && out_valid && !out_stall && issued_q.size() > 0) begin
      req = issued_q.pop_front();
      if (req.cmd == CMD_ALLOC) begin
        if (out_status == STAT_OK) begin
          lb.chunk = out_chunk_index;
          lb.bytes = req.bytes;
          live_blocks.insert(live_blocks.size(), lb);
          granted_count++;
        end else begin
          refused_count++;
        end
      end else begin
        released_count++;
      end
    end
  end

  task automatic push_transaction(logic [CMD_W-1:0] cmd, logic [BYTES_W-1:0] bytes,
                                  logic [ALIGN_W-1:0] align,
                                  logic [CHUNK_SEL_W-1:0] chunk);
    issued_t rec;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_byte_count <= bytes;
    in_alignment  <= align;
    in_free_chunk <= chunk;
    do @(posedge clk); while (in_stall);
    rec.cmd   = cmd;
    rec.bytes = bytes;
    issued_q.insert(issued_q.size(), rec);
    sent_count++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_cmd        <= CMD_W'($urandom);
      in_byte_count <= BYTES_W'($urandom);
      in_alignment  <= ALIGN_W'($urandom);
      in_free_chunk <= CHUNK_SEL_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly well-formed alloc/free traffic, with some raw noise.
  task automatic random_transaction();
    int                 pick;
    int                 k;
    int                 size_band;
    live_block_t        blk;
    logic [BYTES_W-1:0] nbytes;
    logic [ALIGN_W-1:0] nalign;
    pick = $urandom_range(0, 99);
    if (pick < 35 && live_blocks.size() > 0) begin
      k   = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[k];
      live_blocks.delete(k);
      push_transaction(CMD_FREE, blk.bytes, ALIGN_W'($urandom), blk.chunk);
    end else if (pick < 85) begin
      size_band = $urandom_range(0, 99);
      if (size_band < 70) begin
        nbytes = BYTES_W'($urandom_range(0, 512));
      end else if (size_band < 90) begin
        nbytes = BYTES_W'($urandom_range(513, 4096));
      end else begin
        nbytes = BYTES_W'($urandom_range(4097, CHUNK_BYTES));
      end
      nalign = ($urandom_range(0, 5) == 0) ? '0 : (13'd1 << $urandom_range(0, 4));
      push_transaction(CMD_ALLOC, nbytes, nalign, CHUNK_SEL_W'($urandom));
    end else begin
      push_transaction(CMD_W'($urandom), BYTES_W'($urandom), ALIGN_W'($urandom),
                       CHUNK_SEL_W'($urandom));
    end
  endtask

  initial begin
    int burst_len;
    int gap;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_ALLOC;
    in_byte_count = '0;
    in_alignment  = '0;
    in_free_chunk = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: errors, rounding, filling every chunk, resets and saturation
    push_transaction(CMD_ALLOC, 14'd0, 13'd0, 3'd5);
    push_transaction(CMD_ALLOC, 14'd1, 13'd1, 3'd0);
    idle_cycles(1);
    push_transaction(CMD_ALLOC, 14'd16, 13'd16, 3'd0);
    push_transaction(CMD_ALLOC, 14'd17, 13'd17, 3'd0);
    push_transaction(CMD_ALLOC, 14'd8193, 13'd8, 3'd0);
    idle_cycles(2);
    push_transaction(CMD_ALLOC, 14'h3fff, 13'h1fff, 3'd7);
    push_transaction(CMD_ALLOC, 14'h3fff, 13'd4, 3'd0);
    for (int c = 1; c < NUM_CHUNKS; c++) begin
      push_transaction(CMD_ALLOC, 14'(CHUNK_BYTES), 13'd2, 3'd0);
    end
    // chunk 0 holds 32 bytes: one granule too many, then an exact fit
    push_transaction(CMD_ALLOC, 14'(CHUNK_BYTES - 16), 13'd0, 3'd0);
    push_transaction(CMD_ALLOC, 14'(CHUNK_BYTES - 32), 13'd0, 3'd0);
    push_transaction(CMD_ALLOC, 14'd0, 13'd1, 3'd0);
    idle_cycles(3);
    push_transaction(CMD_FREE, 14'(CHUNK_BYTES), 13'h1fff, 3'd1);
    push_transaction(CMD_FREE, 14'(CHUNK_BYTES), 13'd0, 3'd0);
    push_transaction(CMD_FREE, 14'h3fff, 13'd0, 3'd3);
    push_transaction(CMD_FREE, 14'd1, 13'd0, 3'd5);
    // saturate the freed count of an empty chunk; it stays until the fill catches up
    push_transaction(CMD_FREE, 14'h3fff, 13'd0, 3'd1);
    push_transaction(CMD_ALLOC, 14'(CHUNK_BYTES), 13'd16, 3'd0);
    push_transaction(CMD_ALLOC, 14'(CHUNK_BYTES), 13'd16, 3'd0);
    push_transaction(CMD_FREE, 14'd0, 13'd0, 3'd1);

    while (sent_count < RANDOM_ITEMS + 25) begin
      burst_len = $urandom_range(1, 24);
      repeat (burst_len) random_transaction();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      idle_cycles(gap);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d transactions: %0d allocations granted, %0d refused, %0d frees",
             sent_count, granted_count, refused_count, released_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cba_pkg.sv
rtl/cba_cell.sv
rtl/chunked_bump_allocator_unit.sv
tb/sv/alloc_checker.sv
tb/sv/tb.sv
